>>> design/clm_pkg.sv
// ---------------------------------------------------------------------------
// clm_pkg: shared types of the cluster-map cache
// Operation codes, transfer payloads and the stored table entry.
// ---------------------------------------------------------------------------
package clm_pkg;

	// default table depth
	localparam int DEFAULT_CACHE_ENTRIES = 8;

	// operation codes
	typedef enum logic [1:0] {
		FUNC_LOOKUP   = 2'd0,
		FUNC_ADD      = 2'd1,
		FUNC_INV_FILE = 2'd2,
		FUNC_INV_DEV  = 2'd3
	} func_t;

	// result status codes
	typedef enum logic {
		STATUS_OK      = 1'b0,
		STATUS_CORRUPT = 1'b1
	} status_t;

	// request payload
	typedef struct packed {
		func_t       func;
		logic [15:0] device;
		logic [31:0] file_id;
		logic [15:0] cluster;
		logic [15:0] floor_cluster;
		logic [15:0] disk_clu;
	} req_t;

	// response payload
	typedef struct packed {
		logic        hit;
		logic [15:0] found_file_clu;
		logic [15:0] found_disk_clu;
		status_t     status;
	} rsp_t;

	// one stored table entry
	typedef struct packed {
		logic [15:0] device;
		logic [31:0] file_id;
		logic [15:0] file_clu;
		logic [15:0] disk_clu;
	} entry_t;

endpackage

>>> design/clm_stream_if.sv
// ---------------------------------------------------------------------------
// clm_stream_if: valid/ready channel
// Carries one payload per transfer; the payload type is set per instance.
// ---------------------------------------------------------------------------
interface clm_stream_if #(
	parameter type data_t = logic
) ();

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

>>> design/cluster_map_lru_cache.sv
// ---------------------------------------------------------------------------
// cluster_map_lru_cache: cluster-map cache with move-to-front replacement
// Lookup, add and invalidation over a small table kept in recency order.
// ---------------------------------------------------------------------------
//
//   channel  dir  payload        transfer
//   -------  ---  -------------  ------------------------------------------
//   req      in   clm_pkg::req_t one operation, taken while the block is idle
//   rsp      out  clm_pkg::rsp_t one result per operation, held until taken
//
// Each operation rotates the recency list once through the entry memory, one
// entry per cycle, into a single compare stage; an update step then applies
// the result. A new request is taken while an earlier result still waits on
// rsp; the update step waits for the output register to be free. Reset clears
// the valid bits and puts the recency list in index order; no clearing pass.
//
module cluster_map_lru_cache #(
	parameter int CACHE_ENTRIES = clm_pkg::DEFAULT_CACHE_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	clm_stream_if.sink        req,
	clm_stream_if.source      rsp
);

	localparam int IDX_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

	state_t                 state_q;
	clm_pkg::req_t          req_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       order_q [CACHE_ENTRIES];
	logic [IDX_W-1:0]       order_next [CACHE_ENTRIES];
	logic                   valid_q [CACHE_ENTRIES];
	clm_pkg::entry_t        mem [CACHE_ENTRIES];
	clm_pkg::entry_t        rd_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [IDX_W-1:0]       rank_s1;
	logic                   v_s1;
	logic                   best_hit_q;
	logic [15:0]            best_fc_q;
	logic [15:0]            best_dc_q;
	logic                   found_q;
	logic [IDX_W-1:0]       found_idx_q;
	logic [IDX_W-1:0]       found_rank_q;
	logic [15:0]            found_dc_q;
	logic                   out_valid_q;
	clm_pkg::rsp_t          out_q;

	logic                   key_match;
	logic                   dev_match;
	logic                   lookup_cand;
	logic                   add_cand;
	logic                   apply_go;
	logic                   do_move;
	logic                   do_write;
	logic [IDX_W-1:0]       victim;
	logic [IDX_W-1:0]       move_idx;
	logic [IDX_W-1:0]       move_rank;
	logic                   last_rank;

	// handshake
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// shared compare unit on the entry in flight
	assign dev_match   = valid_q[idx_s1] && (rd_s1.device == req_q.device);
	assign key_match   = dev_match && (rd_s1.file_id == req_q.file_id);
	assign lookup_cand = key_match && (rd_s1.file_clu <= req_q.cluster) &&
	                     (rd_s1.file_clu > req_q.floor_cluster) &&
	                     (!best_hit_q || (rd_s1.file_clu > best_fc_q));
	assign last_rank   = (rank_s1 == IDX_W'(CACHE_ENTRIES - 1));
	assign add_cand    = key_match && !last_rank && !found_q &&
	                     (rd_s1.file_clu == req_q.cluster);

	// update decision
	assign apply_go  = (state_q == S_APPLY) && (!out_valid_q || rsp.ready);
	assign victim    = order_q[CACHE_ENTRIES-1];
	assign do_write  = apply_go && (req_q.func == clm_pkg::FUNC_ADD) && !found_q;
	assign do_move   = do_write || (apply_go && (req_q.func == clm_pkg::FUNC_ADD) &&
	                   found_q && (found_dc_q == req_q.disk_clu));
	assign move_idx  = found_q ? found_idx_q : victim;
	assign move_rank = found_q ? found_rank_q : IDX_W'(CACHE_ENTRIES - 1);

	// recency list: rotate during the scan, move to front on update
	always_comb begin
		for (int k = 0; k < CACHE_ENTRIES; k++) begin
			order_next[k] = order_q[k];
		end
		if (state_q == S_SCAN && cnt_q < CNT_W'(CACHE_ENTRIES)) begin
			for (int k = 0; k < CACHE_ENTRIES - 1; k++) begin
				order_next[k] = order_q[k+1];
			end
			order_next[CACHE_ENTRIES-1] = order_q[0];
		end else if (do_move) begin
			order_next[0] = move_idx;
			for (int k = 1; k < CACHE_ENTRIES; k++) begin
				if (IDX_W'(k) <= move_rank) begin
					order_next[k] = order_q[k-1];
				end
			end
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[victim] <= '{device: req_q.device, file_id: req_q.file_id,
			                 file_clu: req_q.cluster,
			                 disk_clu: req_q.disk_clu};
		end
		rd_s1 <= mem[order_q[0]];
	end

	// sequencer, scan stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			cnt_q        <= '0;
			idx_s1       <= '0;
			rank_s1      <= '0;
			v_s1         <= 1'b0;
			best_hit_q   <= 1'b0;
			best_fc_q    <= '0;
			best_dc_q    <= '0;
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			found_rank_q <= '0;
			found_dc_q   <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			for (int k = 0; k < CACHE_ENTRIES; k++) begin
				order_q[k] <= IDX_W'(k);
				valid_q[k] <= 1'b0;
			end
		end else begin
			order_q <= order_next;

			// result register: loaded on update, freed on transfer
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			// compare stage
			if (v_s1) begin
				unique case (req_q.func)
					clm_pkg::FUNC_LOOKUP: begin
						if (lookup_cand) begin
							best_hit_q <= 1'b1;
							best_fc_q  <= rd_s1.file_clu;
							best_dc_q  <= rd_s1.disk_clu;
						end
					end
					clm_pkg::FUNC_ADD: begin
						if (add_cand) begin
							found_q      <= 1'b1;
							found_idx_q  <= idx_s1;
							found_rank_q <= rank_s1;
							found_dc_q   <= rd_s1.disk_clu;
						end
					end
					clm_pkg::FUNC_INV_FILE: begin
						if (key_match) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
					clm_pkg::FUNC_INV_DEV: begin
						if (dev_match) begin
							valid_q[idx_s1] <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					v_s1 <= 1'b0;
					if (req.valid) begin
						req_q      <= req.data;
						cnt_q      <= '0;
						best_hit_q <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q < CNT_W'(CACHE_ENTRIES)) begin
						idx_s1  <= order_q[0];
						rank_s1 <= cnt_q[IDX_W-1:0];
						v_s1    <= 1'b1;
						cnt_q   <= cnt_q + CNT_W'(1);
					end else begin
						v_s1    <= 1'b0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					v_s1 <= 1'b0;
					if (apply_go) begin
						if (do_write) begin
							valid_q[victim] <= (req_q.device != '0);
						end
						if (req_q.func == clm_pkg::FUNC_LOOKUP) begin
							out_q.hit            <= best_hit_q;
							out_q.found_file_clu <= best_hit_q ? best_fc_q
							                                   : req_q.floor_cluster;
							out_q.found_disk_clu <= best_hit_q ? best_dc_q
							                                   : req_q.disk_clu;
							out_q.status         <= clm_pkg::STATUS_OK;
						end else begin
							out_q.hit            <= 1'b0;
							out_q.found_file_clu <= '0;
							out_q.found_disk_clu <= '0;
							out_q.status         <= ((req_q.func == clm_pkg::FUNC_ADD) &&
							                        found_q &&
							                        (found_dc_q != req_q.disk_clu))
							                        ? clm_pkg::STATUS_CORRUPT
							                        : clm_pkg::STATUS_OK;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// a transfer always starts a scan
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_SCAN))
		else $error("request transfer did not start a scan");

	// the update cycle is reached only after a full pass over the list
	a_full_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> (cnt_q == CNT_W'(CACHE_ENTRIES)))
		else $error("update reached before the scan covered every entry");

	// a freshly loaded hit comes only from a lookup and lies within its bounds
	a_hit_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |=> (!out_q.hit || ((req_q.func == clm_pkg::FUNC_LOOKUP) &&
		(out_q.found_file_clu <= req_q.cluster) &&
		(out_q.found_file_clu > req_q.floor_cluster))))
		else $error("hit outside the lookup bounds");

	// corruption status only from an add that found its key
	a_status_add: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |=> ((out_q.status == clm_pkg::STATUS_OK) ||
		((req_q.func == clm_pkg::FUNC_ADD) && found_q)))
		else $error("status set without a matching add");

	// the add search never picks the least-recent entry
	a_found_rank: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (found_rank_q != IDX_W'(CACHE_ENTRIES - 1)))
		else $error("add matched the least-recent entry");
`endif

endmodule
